/* sv/bmpe_pkg.sv */
// Shared types and constants for the binomial mod prime engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bmpe_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned NW           = 12;
  localparam int unsigned RW           = 13;
  localparam int unsigned MaxNDefault  = 1023;
  localparam logic [DataW-1:0] ModulusReset = 32'd1000000007;

  typedef enum logic {
    OpBuild = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusRange    = 2'd1,
    StatusNotBuilt = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    StIdle,
    StFac0,
    StFacMul,
    StFacWait,
    StPowMul,
    StPowMulWait,
    StPowSqWait,
    StInvTop,
    StInvMul,
    StInvWait,
    StQRd1,
    StQRd2,
    StQWait1,
    StQWait2,
    StOut
  } state_e;

  // Request to the shared modular multiplier: a must already be below the modulus.
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } mul_req_t;

endpackage

/* sv/bmpe_modmul.sv */
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle.
// Depends on bmpe_pkg.
`timescale 1ns / 1ps

module bmpe_modmul (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bmpe_pkg::mul_req_t        req_i,
  input  logic [bmpe_pkg::DataW-1:0] modulus_i,
  output logic                      done_o,
  output logic [bmpe_pkg::DataW-1:0] product_o
);
  import bmpe_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] a_q;
  logic [DataW-1:0] b_q;
  logic [DataW-1:0] acc_q;
  logic [DataW-1:0] acc_d;
  logic [DataW:0]   dbl;
  logic [DataW:0]   dbl_red;
  logic [DataW:0]   sum;
  logic [DataW:0]   sum_red;
  logic [DataW:0]   mod_w;

  // Horner step: acc = 2*acc + bit*a, reduced with one subtract after each add.
  always_comb begin
    mod_w   = {1'b0, modulus_i};
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= mod_w) ? dbl - mod_w : dbl;
    sum     = dbl_red + {1'b0, (b_q[DataW-1] ? a_q : '0)};
    sum_red = (sum >= mod_w) ? sum - mod_w : sum;
    acc_d   = sum_red[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[DataW-2:0], 1'b0};
    end
  end

  assign done_o    = done_q;
  assign product_o = (modulus_i[DataW-1:1] == '0) ? '0 : acc_q;

endmodule

/* sv/binomial_mod_prime_engine.sv */
// Query: fac[n] and inv[r] are read from the tables and go through two chained passes
// through the shared bit-serial multiplier, the second with inv[n-r]; the result strobe
// follows the second pass. Error queries and out-of-range r skip the multiplier and go
// straight to the output state. A build also runs on the same multiplier. One item at a
// time; busy is high until the result beat. Reset idles control, reloads the default
// modulus, clears built.
`timescale 1ns / 1ps

module binomial_mod_prime_engine #(
  parameter int unsigned MaxN = bmpe_pkg::MaxNDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [bmpe_pkg::NW-1:0]     n_value_i,
  input  logic signed [bmpe_pkg::RW-1:0] r_value_i,
  output logic                        result_valid_o,
  output logic [bmpe_pkg::DataW-1:0]  value_o,
  output logic [1:0]                  status_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bmpe_pkg::DataW-1:0]  cfg_data_i
);
  import bmpe_pkg::*;

  localparam int unsigned TableDepth = MaxN + 1;
  localparam int unsigned AW         = $clog2(TableDepth);
  localparam logic [AW-1:0] TopIdx   = AW'(MaxN);

  // Two table memories, each with one write and one registered read port.
  logic [DataW-1:0] fac_mem [TableDepth];
  logic [DataW-1:0] inv_mem [TableDepth];

  state_e           state_q, state_d;
  logic [DataW-1:0] modulus_q;
  logic             built_q, built_d;
  logic [NW-1:0]    n_q, n_d;
  logic [NW-1:0]    r_q, r_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [DataW-1:0] prev_q, prev_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] exp_q, exp_d;
  logic [DataW-1:0] res_value_q, res_value_d;
  logic [1:0]       res_status_q, res_status_d;
  logic             res_valid_q, res_valid_d;

  logic             fac_we, inv_we, fac_re, inv_re;
  logic [AW-1:0]    fac_waddr, inv_waddr, fac_raddr, inv_raddr;
  logic [DataW-1:0] fac_wdata, inv_wdata;
  logic [DataW-1:0] fac_rd_q, inv_rd_q;

  mul_req_t         mul_req;
  logic             mul_done;
  logic [DataW-1:0] mul_prod;

  logic             accept;
  logic             cfg_write;
  logic             mod_small;
  logic [DataW-1:0] fac0;
  logic             n_over;
  logic             r_out;

  assign accept    = start && (state_q == StIdle);
  assign cfg_write = cfg_valid_i && cfg_ready_o;
  // A modulus of zero or one turns every product into zero.
  assign mod_small = (modulus_q[DataW-1:1] == '0);
  assign fac0      = mod_small ? '0 : DataW'(1);
  assign n_over    = (DataW'(n_value_i) > DataW'(MaxN));
  assign r_out     = r_value_i[RW-1] || (r_value_i[NW-1:0] > n_value_i);

  bmpe_modmul u_modmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .modulus_i (modulus_q),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (op_i == OpBuild) begin
            state_d = StFac0;
          end else if (!built_q || n_over || r_out) begin
            state_d = StOut;
          end else begin
            state_d = StQRd1;
          end
        end
      end
      StFac0:       state_d = StFacMul;
      StFacMul:     state_d = StFacWait;
      StFacWait: begin
        if (mul_done) begin
          state_d = (idx_q == TopIdx) ? StPowMul : StFacMul;
        end
      end
      StPowMul: begin
        if (exp_q == '0) begin
          state_d = StInvTop;
        end else if (exp_q[0]) begin
          state_d = StPowMulWait;
        end else begin
          state_d = StPowSqWait;
        end
      end
      StPowMulWait: if (mul_done) state_d = StPowSqWait;
      StPowSqWait:  if (mul_done) state_d = StPowMul;
      StInvTop:     state_d = StInvMul;
      StInvMul:     state_d = StInvWait;
      StInvWait: begin
        if (mul_done) begin
          state_d = (idx_q == AW'(1)) ? StOut : StInvMul;
        end
      end
      StQRd1:       state_d = StQRd2;
      StQRd2:       state_d = StQWait1;
      StQWait1:     if (mul_done) state_d = StQWait2;
      StQWait2:     if (mul_done) state_d = StOut;
      StOut:        state_d = StIdle;
      default:      state_d = StIdle;
    endcase
  end

  // Datapath control: multiplier requests, table ports and register updates.
  always_comb begin
    built_d      = built_q;
    n_d          = n_q;
    r_d          = r_q;
    idx_d        = idx_q;
    prev_d       = prev_q;
    acc_d        = acc_q;
    exp_d        = exp_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_valid_d  = 1'b0;
    mul_req      = '0;
    fac_we       = 1'b0;
    inv_we       = 1'b0;
    fac_re       = 1'b0;
    inv_re       = 1'b0;
    fac_waddr    = idx_q;
    inv_waddr    = idx_q - AW'(1);
    fac_wdata    = mul_prod;
    inv_wdata    = mul_prod;
    fac_raddr    = AW'(n_q);
    inv_raddr    = AW'(r_q);
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          n_d          = n_value_i;
          r_d          = r_value_i[NW-1:0];
          res_value_d  = '0;
          res_status_d = StatusOk;
          if (op_i == OpQuery) begin
            if (!built_q) begin
              res_status_d = StatusNotBuilt;
            end else if (n_over) begin
              res_status_d = StatusRange;
            end
          end
        end
      end
      StFac0: begin
        fac_we    = 1'b1;
        fac_waddr = '0;
        fac_wdata = fac0;
        prev_d    = fac0;
        idx_d     = AW'(1);
      end
      StFacMul: begin
        mul_req = '{start: 1'b1, a: prev_q, b: DataW'(idx_q)};
      end
      StFacWait: begin
        if (mul_done) begin
          fac_we = 1'b1;
          prev_d = mul_prod;
          if (idx_q == TopIdx) begin
            acc_d = fac0;
            exp_d = mod_small ? '0 : modulus_q - DataW'(2);
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      StPowMul: begin
        // prev holds the running square of the top factorial.
        if (exp_q != '0) begin
          mul_req.start = 1'b1;
          mul_req.a     = exp_q[0] ? acc_q : prev_q;
          mul_req.b     = prev_q;
        end
      end
      StPowMulWait: begin
        if (mul_done) begin
          acc_d   = mul_prod;
          mul_req = '{start: 1'b1, a: prev_q, b: prev_q};
        end
      end
      StPowSqWait: begin
        if (mul_done) begin
          prev_d = mul_prod;
          exp_d  = exp_q >> 1;
        end
      end
      StInvTop: begin
        inv_we    = 1'b1;
        inv_waddr = TopIdx;
        inv_wdata = acc_q;
        prev_d    = acc_q;
        idx_d     = TopIdx;
      end
      StInvMul: begin
        mul_req = '{start: 1'b1, a: prev_q, b: DataW'(idx_q)};
      end
      StInvWait: begin
        if (mul_done) begin
          inv_we = 1'b1;
          prev_d = mul_prod;
          idx_d  = idx_q - AW'(1);
          if (idx_q == AW'(1)) begin
            built_d = 1'b1;
          end
        end
      end
      StQRd1: begin
        fac_re = 1'b1;
        inv_re = 1'b1;
      end
      StQRd2: begin
        // fac[n] and inv[r] are out now; fetch inv[n-r] behind them.
        inv_re    = 1'b1;
        inv_raddr = AW'(n_q - r_q);
        mul_req   = '{start: 1'b1, a: fac_rd_q, b: inv_rd_q};
      end
      StQWait1: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, a: mul_prod, b: inv_rd_q};
        end
      end
      StQWait2: begin
        if (mul_done) begin
          res_value_d = mul_prod;
        end
      end
      StOut: begin
        res_valid_d = 1'b1;
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      modulus_q    <= ModulusReset;
      built_q      <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_write) begin
        modulus_q <= cfg_data_i;
        built_q   <= 1'b0;
      end else begin
        built_q <= built_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    r_q          <= r_d;
    idx_q        <= idx_d;
    prev_q       <= prev_d;
    acc_q        <= acc_d;
    exp_q        <= exp_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (fac_we) begin
      fac_mem[fac_waddr] <= fac_wdata;
    end
    if (fac_re) begin
      fac_rd_q <= fac_mem[fac_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (inv_we) begin
      inv_mem[inv_waddr] <= inv_wdata;
    end
    if (inv_re) begin
      inv_rd_q <= inv_mem[inv_raddr];
    end
  end

  assign busy           = (state_q != StIdle);
  assign cfg_ready_o    = (state_q == StIdle);
  assign result_valid_o = res_valid_q;
  assign value_o        = res_value_q;
  assign status_o       = res_status_q;

endmodule

/* sv/bmpe_checker.sv */
// Port-level checks for binomial_mod_prime_engine, bound to the top level.
// Depends on bmpe_pkg.
`timescale 1ns / 1ps

module bmpe_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid_o,
  input logic [bmpe_pkg::DataW-1:0] value_o,
  input logic [1:0]                 status_o
);
  import bmpe_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted beat did not raise busy");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy) && !busy) else $error("result beat without work");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != StatusOk) |-> value_o == '0)
    else $error("error status with nonzero value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o <= StatusNotBuilt) else $error("undefined status code");

endmodule

bind binomial_mod_prime_engine bmpe_checker u_bmpe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .value_o        (value_o),
  .status_o       (status_o)
);
